// ===== hw/rtl/btic_pkg.sv =====
`timescale 1ns / 1ps

package btic_pkg;

  localparam int WAYS_DEF = 4;
  localparam int SETS_DEF = 16;
  localparam int WPE_DEF  = 2;

  localparam int PC_W    = 32;
  localparam int INSTR_W = 32;
  localparam int CNT_W   = 2;
  localparam int WADDR_W = 30;

  localparam logic ACT_READ   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_WB
  } state_t;

  function automatic int plru_width(input int ways);
    return (ways >= 8) ? 7 : 3;
  endfunction

  function automatic int tag_width(input int sets);
    return WADDR_W - $clog2(sets + 1) + 1;
  endfunction

endpackage

// ===== hw/rtl/btic_addr_split.sv =====
`timescale 1ns / 1ps

module btic_addr_split #(
  parameter int SETS  = btic_pkg::SETS_DEF,
  parameter int SET_W = $clog2(btic_pkg::SETS_DEF),
  parameter int TAG_W = btic_pkg::tag_width(btic_pkg::SETS_DEF)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [btic_pkg::PC_W-1:0] word_i,
  output logic                      done_o,
  output logic [SET_W-1:0]          set_o,
  output logic [TAG_W-1:0]          tag_o
);

  localparam bit IS_POW2 = (SETS & (SETS - 1)) == 0;

  generate
    if (IS_POW2) begin : g_pow2
      logic [SET_W-1:0] set_r;
      logic [TAG_W-1:0] tag_r;

      always_ff @(posedge clk) begin
        if (start_i) begin
          set_r <= word_i[SET_W-1:0];
          tag_r <= word_i[SET_W +: TAG_W];
        end
      end

      assign done_o = 1'b1;
      assign set_o  = set_r;
      assign tag_o  = tag_r;
    end else begin : g_div
      localparam int WW     = btic_pkg::WADDR_W;
      localparam int RW     = btic_pkg::PC_W;
      localparam int PROD_W = WW + RW;
      localparam int SH     = WW + SET_W;
      localparam longint RECIP = ((longint'(1) << SH) + longint'(SETS) - 1) / longint'(SETS);
      localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
      localparam logic [WW-1:0] SETS_V  = WW'(SETS);

      logic              quo_pend_r;
      logic              rem_pend_r;
      logic [WW-1:0]     word_r;
      logic [WW-1:0]     quo_r;
      logic [SET_W-1:0]  rem_r;
      logic [PROD_W-1:0] prod;
      logic [WW-1:0]     back;

      assign prod = {{WW{1'b0}}, RECIP_V} * {{RW{1'b0}}, word_r};
      assign back = quo_r * SETS_V;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          quo_pend_r <= 1'b0;
          rem_pend_r <= 1'b0;
        end else begin
          quo_pend_r <= start_i;
          rem_pend_r <= quo_pend_r;
        end
      end

      always_ff @(posedge clk) begin
        if (start_i) begin
          word_r <= word_i[WW-1:0];
        end
        if (quo_pend_r) begin
          quo_r <= WW'(prod >> SH);
        end
        if (rem_pend_r) begin
          rem_r <= SET_W'(word_r - back);
        end
      end

      assign done_o = !quo_pend_r && !rem_pend_r;
      assign set_o  = rem_r;
      assign tag_o  = quo_r[TAG_W-1:0];
    end
  endgenerate

endmodule

// ===== hw/rtl/btic_store.sv =====
`timescale 1ns / 1ps

module btic_store #(
  parameter int SETS   = btic_pkg::SETS_DEF,
  parameter int SET_W  = $clog2(btic_pkg::SETS_DEF),
  parameter int META_W = 8,
  parameter int LANES  = 8,
  parameter int WORD_W = btic_pkg::INSTR_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    rd_en_i,
  input  logic [SET_W-1:0]        rd_set_i,
  input  logic                    wr_en_i,
  input  logic [SET_W-1:0]        wr_set_i,
  input  logic [META_W-1:0]       wr_meta_i,
  input  logic [LANES-1:0]        wr_lane_en_i,
  input  logic [LANES*WORD_W-1:0] wr_words_i,
  output logic [META_W-1:0]       rd_meta_o,
  output logic [LANES*WORD_W-1:0] rd_words_o
);

  logic [META_W-1:0]       meta_mem [SETS];
  logic [LANES*WORD_W-1:0] word_mem [SETS];
  logic [SETS-1:0]         rowv_r;
  logic                    rowv_q_r;
  logic [META_W-1:0]       meta_q_r;
  logic [LANES*WORD_W-1:0] words_q_r;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      meta_mem[wr_set_i] <= wr_meta_i;
    end
    if (rd_en_i) begin
      meta_q_r <= meta_mem[rd_set_i];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (wr_en_i && wr_lane_en_i[l]) begin
        word_mem[wr_set_i][l*WORD_W +: WORD_W] <= wr_words_i[l*WORD_W +: WORD_W];
      end
    end
    if (rd_en_i) begin
      words_q_r <= word_mem[rd_set_i];
    end
  end

  // A row never written reads its metadata as all zero, which means no valid way and
  // cleared tree bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowv_r   <= '0;
      rowv_q_r <= 1'b0;
    end else begin
      if (wr_en_i) begin
        rowv_r[wr_set_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rowv_q_r <= rowv_r[rd_set_i];
      end
    end
  end

  assign rd_meta_o  = rowv_q_r ? meta_q_r : '0;
  assign rd_words_o = words_q_r;

endmodule

// ===== hw/rtl/btic_lookup.sv =====
`timescale 1ns / 1ps

module btic_lookup #(
  parameter int WAYS   = btic_pkg::WAYS_DEF,
  parameter int WPE    = btic_pkg::WPE_DEF,
  parameter int TAG_W  = btic_pkg::tag_width(btic_pkg::SETS_DEF),
  parameter int PLRU_W = btic_pkg::plru_width(btic_pkg::WAYS_DEF),
  parameter int META_W = 8,
  parameter int LANES  = 8
) (
  input  logic [META_W-1:0]                    meta_i,
  input  logic [LANES*btic_pkg::INSTR_W-1:0]   words_i,
  input  logic                                 action_i,
  input  logic [TAG_W-1:0]                     tag_i,
  input  logic [btic_pkg::CNT_W-1:0]           count_i,
  input  logic [btic_pkg::INSTR_W-1:0]         first_i,
  input  logic [btic_pkg::INSTR_W-1:0]         second_i,
  output logic                                 hit_o,
  output logic [btic_pkg::CNT_W-1:0]           count_o,
  output logic [btic_pkg::INSTR_W-1:0]         word_first_o,
  output logic [btic_pkg::INSTR_W-1:0]         word_second_o,
  output logic [META_W-1:0]                    meta_o,
  output logic [LANES-1:0]                     lane_en_o,
  output logic [LANES*btic_pkg::INSTR_W-1:0]   words_o
);

  localparam int CW    = btic_pkg::CNT_W;
  localparam int IW    = btic_pkg::INSTR_W;
  localparam int ENT_W = 1 + TAG_W + CW;
  localparam logic [CW-1:0] WPE_V = CW'(WPE);

  localparam logic [6:0] PB0 = 7'b000_0001;
  localparam logic [6:0] PB1 = 7'b000_0010;
  localparam logic [6:0] PB2 = 7'b000_0100;
  localparam logic [6:0] PB3 = 7'b000_1000;
  localparam logic [6:0] PB4 = 7'b001_0000;
  localparam logic [6:0] PB5 = 7'b010_0000;
  localparam logic [6:0] PB6 = 7'b100_0000;

  always_comb begin
    logic [6:0]    b;
    logic [6:0]    nb;
    logic          found;
    logic [2:0]    hw;
    logic [CW-1:0] hcnt;
    logic          vfound;
    logic [2:0]    vw;
    logic [CW-1:0] ucnt;
    logic          upd;

    b      = 7'(meta_i[WAYS*ENT_W +: PLRU_W]);
    upd    = (action_i == btic_pkg::ACT_UPDATE);
    found  = 1'b0;
    hw     = '0;
    hcnt   = '0;
    vfound = 1'b0;
    vw     = '0;

    for (int w = 0; w < WAYS; w++) begin
      if (!found && meta_i[w*ENT_W + ENT_W - 1] && meta_i[w*ENT_W + CW +: TAG_W] == tag_i) begin
        found = 1'b1;
        hw    = 3'(w);
        hcnt  = meta_i[w*ENT_W +: CW];
      end
      if (!vfound && !meta_i[w*ENT_W + ENT_W - 1]) begin
        vfound = 1'b1;
        vw     = 3'(w);
      end
    end

    nb = b;
    if (WAYS >= 8) begin
      case (hw)
        3'd0:    nb = b | PB0 | PB1 | PB3;
        3'd1:    nb = (b | PB0 | PB1) & ~PB3;
        3'd2:    nb = (b | PB0 | PB4) & ~PB1;
        3'd3:    nb = (b | PB0) & ~(PB1 | PB4);
        3'd4:    nb = (b | PB2 | PB5) & ~PB0;
        3'd5:    nb = (b | PB2) & ~(PB0 | PB5);
        3'd6:    nb = (b | PB6) & ~(PB0 | PB2);
        3'd7:    nb = b & ~(PB0 | PB2 | PB6);
        default: nb = b;
      endcase
    end else begin
      case (hw)
        3'd0:    nb = b | PB0 | PB1;
        3'd1:    nb = (b | PB0) & ~PB1;
        3'd2:    nb = (b | PB2) & ~PB0;
        3'd3:    nb = b & ~(PB0 | PB2);
        default: nb = b;
      endcase
    end

    if (!vfound) begin
      if (WAYS >= 8) begin
        if ((b & PB0) != '0) begin
          if ((b & PB2) != '0) begin
            vw = ((b & PB5) != '0) ? 3'd5 : 3'd4;
          end else begin
            vw = ((b & PB6) != '0) ? 3'd7 : 3'd6;
          end
        end else if ((b & PB1) != '0) begin
          vw = ((b & PB4) != '0) ? 3'd3 : 3'd2;
        end else begin
          vw = ((b & PB3) != '0) ? 3'd1 : 3'd0;
        end
      end else if ((b & PB0) != '0) begin
        vw = ((b & PB2) != '0) ? 3'd3 : 3'd2;
      end else begin
        vw = ((b & PB1) != '0) ? 3'd1 : 3'd0;
      end
    end

    ucnt = (count_i > WPE_V) ? WPE_V : count_i;

    meta_o = meta_i;
    if (upd) begin
      meta_o[vw*ENT_W +: ENT_W] = {1'b1, tag_i, ucnt};
    end else if (found) begin
      meta_o[WAYS*ENT_W +: PLRU_W] = nb[PLRU_W-1:0];
    end

    for (int w = 0; w < WAYS; w++) begin
      for (int i = 0; i < WPE; i++) begin
        lane_en_o[w*WPE + i] = upd && (vw == 3'(w)) && (CW'(i) < ucnt);
        words_o[(w*WPE + i)*IW +: IW] = (i == 0) ? first_i : second_i;
      end
    end

    hit_o        = found;
    count_o      = found ? hcnt : '0;
    word_first_o = (found && hcnt >= CW'(1)) ? words_i[(hw*WPE)*IW +: IW] : '0;
    if (WPE >= 2 && found && hcnt >= CW'(2)) begin
      word_second_o = words_i[(hw*WPE + 1)*IW +: IW];
    end else begin
      word_second_o = '0;
    end
  end

endmodule

// ===== hw/rtl/branch_target_instr_cache.sv =====
`timescale 1ns / 1ps
// A read beat follows the set and tag split, the row read and the result register;
// for other SETS the tag comes from reciprocal division, then the set as the remainder.
// A new item is taken when idle or at the write-back of the last one, since each set's row is
// read and then written back; a read waits in write-back until the result register is free, and
// updates produce no beat. Reset clears the row valid flags, so no clearing pass is needed.

module branch_target_instr_cache #(
  parameter int WAYS            = btic_pkg::WAYS_DEF,
  parameter int SETS            = btic_pkg::SETS_DEF,
  parameter int WORDS_PER_ENTRY = btic_pkg::WPE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [btic_pkg::PC_W-1:0]     in_pc,
  input  logic [btic_pkg::CNT_W-1:0]    in_instr_count,
  input  logic [btic_pkg::INSTR_W-1:0]  in_instr_first,
  input  logic [btic_pkg::INSTR_W-1:0]  in_instr_second,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [btic_pkg::CNT_W-1:0]    out_count_out,
  output logic [btic_pkg::INSTR_W-1:0]  out_word_first,
  output logic [btic_pkg::INSTR_W-1:0]  out_word_second
);

  localparam int SET_W  = $clog2(SETS);
  localparam int TAG_W  = btic_pkg::tag_width(SETS);
  localparam int PLRU_W = btic_pkg::plru_width(WAYS);
  localparam int ENT_W  = 1 + TAG_W + btic_pkg::CNT_W;
  localparam int META_W = PLRU_W + WAYS * ENT_W;
  localparam int LANES  = WAYS * WORDS_PER_ENTRY;
  localparam int IW     = btic_pkg::INSTR_W;

  btic_pkg::state_t state_r, state_nxt;

  logic                       action_r;
  logic [btic_pkg::CNT_W-1:0] cnt_r;
  logic [IW-1:0]              first_r;
  logic [IW-1:0]              second_r;

  logic                       out_valid_r;
  logic                       out_hit_r;
  logic [btic_pkg::CNT_W-1:0] out_count_r;
  logic [IW-1:0]              out_first_r;
  logic [IW-1:0]              out_second_r;

  logic split_start, split_done;
  logic rd_en, wr_en, out_load, go;
  logic in_accept;

  logic [SET_W-1:0]           set_w;
  logic [TAG_W-1:0]           tag_w;
  logic [META_W-1:0]          rd_meta, wr_meta;
  logic [LANES*IW-1:0]        rd_words, wr_words;
  logic [LANES-1:0]           lane_en;
  logic                       lk_hit;
  logic [btic_pkg::CNT_W-1:0] lk_count;
  logic [IW-1:0]              lk_first, lk_second;

  btic_addr_split #(
    .SETS  (SETS),
    .SET_W (SET_W),
    .TAG_W (TAG_W)
  ) u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (split_start),
    .word_i  ({2'b00, in_pc[btic_pkg::PC_W-1:2]}),
    .done_o  (split_done),
    .set_o   (set_w),
    .tag_o   (tag_w)
  );

  btic_store #(
    .SETS   (SETS),
    .SET_W  (SET_W),
    .META_W (META_W),
    .LANES  (LANES),
    .WORD_W (IW)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .rd_en_i      (rd_en),
    .rd_set_i     (set_w),
    .wr_en_i      (wr_en),
    .wr_set_i     (set_w),
    .wr_meta_i    (wr_meta),
    .wr_lane_en_i (lane_en),
    .wr_words_i   (wr_words),
    .rd_meta_o    (rd_meta),
    .rd_words_o   (rd_words)
  );

  btic_lookup #(
    .WAYS   (WAYS),
    .WPE    (WORDS_PER_ENTRY),
    .TAG_W  (TAG_W),
    .PLRU_W (PLRU_W),
    .META_W (META_W),
    .LANES  (LANES)
  ) u_lookup (
    .meta_i        (rd_meta),
    .words_i       (rd_words),
    .action_i      (action_r),
    .tag_i         (tag_w),
    .count_i       (cnt_r),
    .first_i       (first_r),
    .second_i      (second_r),
    .hit_o         (lk_hit),
    .count_o       (lk_count),
    .word_first_o  (lk_first),
    .word_second_o (lk_second),
    .meta_o        (wr_meta),
    .lane_en_o     (lane_en),
    .words_o       (wr_words)
  );

  assign in_accept = in_valid && in_ready;
  assign go        = (action_r == btic_pkg::ACT_UPDATE) || !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    split_start = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      btic_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          split_start = 1'b1;
          state_nxt   = btic_pkg::ST_SPLIT;
        end
      end
      btic_pkg::ST_SPLIT: begin
        if (split_done) begin
          rd_en     = 1'b1;
          state_nxt = btic_pkg::ST_WB;
        end
      end
      btic_pkg::ST_WB: begin
        if (go) begin
          wr_en       = 1'b1;
          out_load    = (action_r == btic_pkg::ACT_READ);
          in_ready    = 1'b1;
          split_start = in_valid;
          state_nxt   = in_valid ? btic_pkg::ST_SPLIT : btic_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btic_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btic_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      action_r <= in_action;
      cnt_r    <= in_instr_count;
      first_r  <= in_instr_first;
      second_r <= in_instr_second;
    end
    if (out_load) begin
      out_hit_r    <= lk_hit;
      out_count_r  <= lk_count;
      out_first_r  <= lk_first;
      out_second_r <= lk_second;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_count_out   = out_count_r;
  assign out_word_first  = out_first_r;
  assign out_word_second = out_second_r;

  a_read_then_wb: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == btic_pkg::ST_WB))
    else $error("row read not followed by write-back");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !wr_en)
    else $error("row read and write in the same cycle");

  a_beat_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      $past(state_r == btic_pkg::ST_WB && action_r == btic_pkg::ACT_READ))
    else $error("result beat without a read in write-back");

  a_no_accept_split: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == btic_pkg::ST_SPLIT) |-> !in_ready)
    else $error("input accepted while an item is in flight");

endmodule
